[rtl/core/jht_pkg.sv]
// Shared types, widths and constants for the joint homogeneous transform core.
// Holds the degree-domain CORDIC arctangent table and the axis codes.
// No dependencies.
`default_nettype none

package jht_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int AXIS_W  = 2;
    localparam int LINK_W  = 32;
    localparam int ROT_W   = 16;

    // Internal datapath widths: Q2.30 rotator state and degree*2^22 angle
    localparam int XW = 34;
    localparam int ZW = 32;

    // Default number of CORDIC iterations (8 to 24)
    localparam int CORDIC_STEPS_DEF = 16;

    // Angle constants in 1/64 degree
    localparam int ANG_FULL          = 23040;
    localparam int ANG_HALF          = 11520;
    localparam int ANG_QUARTER       = 5760;
    localparam int ANG_THREE_QUARTER = 17280;

    // CORDIC start value: inverse gain in Q2.30
    localparam int GAIN_Q30 = 652032874;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic        [AXIS_W-1:0]  axis_code_t;
    typedef logic signed [LINK_W-1:0]  link_t;
    typedef logic signed [ROT_W-1:0]   rot_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // atan(2^-i) in degrees * 2^22
    function automatic logic signed [ZW-1:0] atan_deg_q22(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = 32'sd188743680;
            1:       a = 32'sd111421900;
            2:       a = 32'sd58872272;
            3:       a = 32'sd29884485;
            4:       a = 32'sd15000234;
            5:       a = 32'sd7507429;
            6:       a = 32'sd3754631;
            7:       a = 32'sd1877430;
            8:       a = 32'sd938729;
            9:       a = 32'sd469366;
            10:      a = 32'sd234683;
            11:      a = 32'sd117342;
            12:      a = 32'sd58671;
            13:      a = 32'sd29335;
            14:      a = 32'sd14668;
            15:      a = 32'sd7334;
            16:      a = 32'sd3667;
            17:      a = 32'sd1833;
            18:      a = 32'sd917;
            19:      a = 32'sd458;
            20:      a = 32'sd229;
            21:      a = 32'sd115;
            22:      a = 32'sd57;
            23:      a = 32'sd29;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[rtl/core/jht_pose_if.sv]
// Input channel of the joint homogeneous transform core: joint angle, axis, link.
// Depends on jht_pkg.
`default_nettype none

interface jht_pose_if import jht_pkg::*; ();
    logic       valid;
    logic       ready;
    angle_t     angle_deg;
    axis_code_t axis_select;
    link_t      link_x;
    link_t      link_y;
    link_t      link_z;

    modport source (
        output valid, angle_deg, axis_select, link_x, link_y, link_z,
        input  ready
    );

    modport sink (
        input  valid, angle_deg, axis_select, link_x, link_y, link_z,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/jht_frame_if.sv]
// Output channel of the joint homogeneous transform core: rotation and translation.
// Depends on jht_pkg.
`default_nettype none

interface jht_frame_if import jht_pkg::*; ();
    logic  valid;
    logic  ready;
    rot_t  rot_00;
    rot_t  rot_01;
    rot_t  rot_02;
    rot_t  rot_10;
    rot_t  rot_11;
    rot_t  rot_12;
    rot_t  rot_20;
    rot_t  rot_21;
    rot_t  rot_22;
    link_t trans_x;
    link_t trans_y;
    link_t trans_z;

    modport source (
        output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
               rot_20, rot_21, rot_22, trans_x, trans_y, trans_z,
        input  ready
    );

    modport sink (
        input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
               rot_20, rot_21, rot_22, trans_x, trans_y, trans_z,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/joint_homogeneous_transform_core.sv]
// Joint homogeneous transform core: angle reduction, pipelined CORDIC, matrix build,
// rotated link offset. Depends on jht_pkg, jht_pose_if and jht_frame_if.
//
// The core takes one joint pose per clock cycle unless a stalled output has filled every
// stage, and presents the upper three rows of its homogeneous transform in the output
// register once the pose has passed through all the stages listed below. An angle
// reduction stage comes first, then each CORDIC iteration has a register stage of its
// own, followed by a clamp stage, a multiply stage (four 32x32 products), a sum stage
// that adds the rounding offset and a saturate stage that is also the output register.
// Every stage keeps its own valid bit and loads while it is empty or its successor
// moves, so bubbles close up under an output stall and new poses keep entering while
// a finished result waits to be taken. Sine and cosine stay in the degree domain; any
// axis code other than x or y selects z.
`default_nettype none

module joint_homogeneous_transform_core import jht_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    jht_pose_if.sink     pose,
    jht_frame_if.source  frame
);

    // Stage indices: 0 reduce, 1..N CORDIC, then clamp, product, sum, output
    localparam int ST_CLAMP = CORDIC_STEPS + 1;
    localparam int ST_PROD  = CORDIC_STEPS + 2;
    localparam int ST_SUM   = CORDIC_STEPS + 3;
    localparam int LAST     = CORDIC_STEPS + 4;

    localparam logic signed [XW-1:0] POS_ONE  = XW'(64'sd1 <<< 30);
    localparam logic signed [XW-1:0] NEG_ONE  = -POS_ONE;
    localparam logic signed [63:0]   HALF_LSB = 64'sd1 <<< 29;
    localparam logic signed [63:0]   SAT_MAX  = 64'sd2147483647;
    localparam logic signed [63:0]   SAT_MIN  = -64'sd2147483648;

    // Clamp a rotator output to [-1, 1] in Q2.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > POS_ONE) begin
            r = 32'(POS_ONE);
        end else if (v < NEG_ONE) begin
            r = 32'(NEG_ONE);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round Q2.30 to Q2.14, floor((v + 2^15) / 2^16)
    function automatic rot_t round_q14(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v + 32'sd32768;
        return t[31:16];
    endfunction

    // Drop Q2.30 fraction and saturate to signed 32 bits
    function automatic link_t sat32(input logic signed [63:0] acc);
        logic signed [63:0] v;
        link_t r;
        v = acc >>> 30;
        if (v > SAT_MAX) begin
            r = link_t'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = link_t'(SAT_MIN);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [LAST:0] valid_reg;
    logic [LAST:0] valid_next;
    logic [LAST:0] en;

    assign en[LAST]   = !valid_reg[LAST] || frame.ready;
    assign valid_next = {valid_reg[LAST-1:0], pose.valid};

    for (genvar k = 0; k < LAST; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    // Advance valid bits with their stage
    for (genvar k = 0; k <= LAST; k++) begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    assign pose.ready  = en[0];
    assign frame.valid = valid_reg[LAST];

    // ------------------------------------------------------------------
    // Stage 0: reduce angle modulo one turn, fold into [-90, 90] degrees
    // ------------------------------------------------------------------
    logic signed [17:0] ang_shift;
    logic signed [17:0] ang_mod_a;
    logic signed [17:0] ang_mod;
    logic signed [17:0] ang_fold;
    logic               flip_next;

    always_comb
    begin
        ang_shift = 18'(pose.angle_deg) + 18'sd46080;
        ang_mod_a = (ang_shift >= 18'sd46080) ? ang_shift - 18'sd46080 : ang_shift;
        ang_mod   = (ang_mod_a >= 18'(ANG_FULL)) ? ang_mod_a - 18'(ANG_FULL) : ang_mod_a;
        flip_next = 1'b0;
        if (ang_mod > 18'(ANG_THREE_QUARTER)) begin
            ang_fold = ang_mod - 18'(ANG_FULL);
        end else if (ang_mod > 18'(ANG_QUARTER)) begin
            ang_fold  = ang_mod - 18'(ANG_HALF);
            flip_next = 1'b1;
        end else begin
            ang_fold = ang_mod;
        end
    end

    logic signed [XW-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg    [0:CORDIC_STEPS];
    logic                 flip_reg [0:CORDIC_STEPS];
    axis_code_t           axis_reg [0:CORDIC_STEPS];
    link_t                lx_reg   [0:CORDIC_STEPS];
    link_t                ly_reg   [0:CORDIC_STEPS];
    link_t                lz_reg   [0:CORDIC_STEPS];

    // Load the reduced angle and start vector
    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            x_reg[0]    <= XW'(GAIN_Q30);
            y_reg[0]    <= '0;
            z_reg[0]    <= ZW'(ang_fold) <<< 16;
            flip_reg[0] <= flip_next;
            axis_reg[0] <= pose.axis_select;
            lx_reg[0]   <= pose.link_x;
            ly_reg[0]   <= pose.link_y;
            lz_reg[0]   <= pose.link_z;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..N: one CORDIC rotation each
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_cordic
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;

        assign dx = x_reg[k-1] >>> (k - 1);
        assign dy = y_reg[k-1] >>> (k - 1);
        assign da = atan_deg_q22(k - 1);

        // Rotate towards zero residual angle
        always_ff @(posedge clk)
        begin
            if (en[k]) begin
                if (!z_reg[k-1][ZW-1]) begin
                    x_reg[k] <= x_reg[k-1] - dy;
                    y_reg[k] <= y_reg[k-1] + dx;
                    z_reg[k] <= z_reg[k-1] - da;
                end else begin
                    x_reg[k] <= x_reg[k-1] + dy;
                    y_reg[k] <= y_reg[k-1] - dx;
                    z_reg[k] <= z_reg[k-1] + da;
                end
                flip_reg[k] <= flip_reg[k-1];
                axis_reg[k] <= axis_reg[k-1];
                lx_reg[k]   <= lx_reg[k-1];
                ly_reg[k]   <= ly_reg[k-1];
                lz_reg[k]   <= lz_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp stage: undo the half-turn fold, clamp cos and sin
    // ------------------------------------------------------------------
    logic signed [XW-1:0] xf;
    logic signed [XW-1:0] yf;
    logic signed [31:0]   c_reg;
    logic signed [31:0]   s_reg;
    axis_code_t           axis_c_reg;
    link_t                lx_c_reg;
    link_t                ly_c_reg;
    link_t                lz_c_reg;

    assign xf = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign yf = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en[ST_CLAMP]) begin
            c_reg      <= clamp_q30(xf);
            s_reg      <= clamp_q30(yf);
            axis_c_reg <= axis_reg[CORDIC_STEPS];
            lx_c_reg   <= lx_reg[CORDIC_STEPS];
            ly_c_reg   <= ly_reg[CORDIC_STEPS];
            lz_c_reg   <= lz_reg[CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Product stage: build the matrix, multiply the in-plane link pair
    // ------------------------------------------------------------------
    rot_t  cq;
    rot_t  sq;
    rot_t  nsq;
    rot_t  rot_next [9];
    link_t la;
    link_t lb;
    link_t lu;

    assign cq  = round_q14(c_reg);
    assign sq  = round_q14(s_reg);
    assign nsq = round_q14(-s_reg);

    // Pick the rotation plane (a, b) and the fixed axis u
    always_comb
    begin
        for (int i = 0; i < 9; i++) begin
            rot_next[i] = '0;
        end
        case (axis_c_reg)
            AXIS_X:
            begin
                rot_next[0] = 16'sd16384;
                rot_next[4] = cq;
                rot_next[5] = nsq;
                rot_next[7] = sq;
                rot_next[8] = cq;
                la = ly_c_reg;
                lb = lz_c_reg;
                lu = lx_c_reg;
            end
            AXIS_Y:
            begin
                rot_next[0] = cq;
                rot_next[2] = nsq;
                rot_next[4] = 16'sd16384;
                rot_next[6] = sq;
                rot_next[8] = cq;
                la = lx_c_reg;
                lb = lz_c_reg;
                lu = ly_c_reg;
            end
            default:
            begin
                rot_next[0] = cq;
                rot_next[1] = nsq;
                rot_next[3] = sq;
                rot_next[4] = cq;
                rot_next[8] = 16'sd16384;
                la = lx_c_reg;
                lb = ly_c_reg;
                lu = lz_c_reg;
            end
        endcase
    end

    logic signed [63:0] p_ca_reg;
    logic signed [63:0] p_sb_reg;
    logic signed [63:0] p_sa_reg;
    logic signed [63:0] p_cb_reg;
    rot_t               rot_p_reg [9];
    axis_code_t         axis_p_reg;
    link_t              lu_p_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD]) begin
            p_ca_reg   <= c_reg * la;
            p_sb_reg   <= s_reg * lb;
            p_sa_reg   <= s_reg * la;
            p_cb_reg   <= c_reg * lb;
            rot_p_reg  <= rot_next;
            axis_p_reg <= axis_c_reg;
            lu_p_reg   <= lu;
        end
    end

    // ------------------------------------------------------------------
    // Sum stage: rotated pair plus rounding offset
    // ------------------------------------------------------------------
    logic signed [63:0] acc_a_reg;
    logic signed [63:0] acc_b_reg;
    rot_t               rot_s_reg [9];
    axis_code_t         axis_s_reg;
    link_t              lu_s_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM]) begin
            acc_a_reg  <= p_ca_reg - p_sb_reg + HALF_LSB;
            acc_b_reg  <= p_sa_reg + p_cb_reg + HALF_LSB;
            rot_s_reg  <= rot_p_reg;
            axis_s_reg <= axis_p_reg;
            lu_s_reg   <= lu_p_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturate and place the translation by axis
    // ------------------------------------------------------------------
    link_t ta;
    link_t tb;
    link_t tx_next;
    link_t ty_next;
    link_t tz_next;

    assign ta = sat32(acc_a_reg);
    assign tb = sat32(acc_b_reg);

    always_comb
    begin
        case (axis_s_reg)
            AXIS_X:
            begin
                tx_next = lu_s_reg;
                ty_next = ta;
                tz_next = tb;
            end
            AXIS_Y:
            begin
                tx_next = ta;
                ty_next = lu_s_reg;
                tz_next = tb;
            end
            default:
            begin
                tx_next = ta;
                ty_next = tb;
                tz_next = lu_s_reg;
            end
        endcase
    end

    rot_t  rot_o_reg [9];
    link_t tx_reg;
    link_t ty_reg;
    link_t tz_reg;

    // Hold the result until the output transfer
    always_ff @(posedge clk)
    begin
        if (en[LAST]) begin
            rot_o_reg <= rot_s_reg;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            tz_reg    <= tz_next;
        end
    end

    assign frame.rot_00  = rot_o_reg[0];
    assign frame.rot_01  = rot_o_reg[1];
    assign frame.rot_02  = rot_o_reg[2];
    assign frame.rot_10  = rot_o_reg[3];
    assign frame.rot_11  = rot_o_reg[4];
    assign frame.rot_12  = rot_o_reg[5];
    assign frame.rot_20  = rot_o_reg[6];
    assign frame.rot_21  = rot_o_reg[7];
    assign frame.rot_22  = rot_o_reg[8];
    assign frame.trans_x = tx_reg;
    assign frame.trans_y = ty_reg;
    assign frame.trans_z = tz_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An empty output register means nothing can block the input
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !frame.valid |-> pose.ready
    ) else $error("input stalled with empty output register");

    // A result moving out of the sum stage lands in the output register
    a_sum_to_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (en[LAST] && valid_reg[ST_SUM]) |=> frame.valid
    ) else $error("result lost between sum and output stage");

    // Clamped cosine and sine stay within one
    a_clamp_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg[ST_CLAMP] |-> (c_reg <= 32'(POS_ONE) && c_reg >= 32'(NEG_ONE) &&
                                 s_reg <= 32'(POS_ONE) && s_reg >= 32'(NEG_ONE))
    ) else $error("cosine or sine outside [-1, 1]");

    // The first and last diagonal entries never exceed one in Q2.14
    a_rot_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        frame.valid |-> (frame.rot_00 <= 16'sd16384 && frame.rot_00 >= -16'sd16384 &&
                         frame.rot_22 <= 16'sd16384 && frame.rot_22 >= -16'sd16384)
    ) else $error("rotation entry out of range");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for joint_homogeneous_transform_core: directed poses, then random ones.
// Depends on jht_pkg, jht_pose_if, jht_frame_if and the core itself.
`timescale 1ns / 1ps

module testbench import jht_pkg::*; ();

    localparam int  STEPS        = 16;
    localparam int  HALF_PERIOD  = 10;
    localparam int  RANDOM_POSES = 1300;
    localparam int  LONG_HOLD    = 240;
    localparam int  WATCHDOG_NS  = 4000000;
    localparam int  DIR_N        = 21;

    localparam longint ONE_Q30  = 64'sd1 <<< 30;
    localparam longint RAIL_MAX = 64'sd2147483647;
    localparam longint RAIL_MIN = -64'sd2147483648;

    localparam rot_t       ROT_ONE    = 16'sd16384;
    localparam link_t      LINK_MAX   = 32'sh7FFF_FFFF;
    localparam link_t      LINK_MIN   = 32'sh8000_0000;
    localparam axis_code_t AXIS_SPARE = 2'd3;

    // atan(2^-i) in degrees * 2^22
    localparam longint ATAN_Q22 [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        angle_t     angle;
        axis_code_t axis;
        link_t      lx;
        link_t      ly;
        link_t      lz;
    } pose_rec_t;

    typedef struct packed {
        rot_t  [8:0] rot;
        link_t [2:0] trans;
    } frame_rec_t;

    // Directed row: pose plus the translation along the rotation axis, which passes unchanged
    typedef struct packed {
        angle_t     angle;
        axis_code_t axis;
        link_t      lx;
        link_t      ly;
        link_t      lz;
        link_t      axis_trans;
    } dir_row_t;

    dir_row_t dir_table [DIR_N] = '{
        '{16'sd0,      AXIS_X,     32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
          32'sh0001_0000},
        '{16'sd23040,  AXIS_Y,     32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
          32'sh0002_0000},
        '{-16'sd23040, AXIS_Z,     32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
          32'sh0003_0000},
        '{16'sd5760,   AXIS_X,     LINK_MAX, LINK_MAX, LINK_MAX, LINK_MAX},
        '{-16'sd5760,  AXIS_Y,     LINK_MIN, LINK_MIN, LINK_MIN, LINK_MIN},
        '{16'sd11520,  AXIS_Z,     LINK_MIN, LINK_MIN, LINK_MIN, LINK_MIN},
        '{-16'sd11520, AXIS_X,     LINK_MAX, LINK_MIN, LINK_MAX, LINK_MAX},
        '{16'sd17280,  AXIS_SPARE, 32'sh0001_0000, -32'sd65536, 32'sd32768, 32'sd32768},
        '{16'sd17281,  AXIS_Z,     32'sh0001_0000, 32'sh0001_0000, -32'sd65536,
          -32'sd65536},
        '{16'sd5761,   AXIS_Y,     32'sh0000_8000, 32'sh7FFF_0000, 32'sh0000_0001,
          32'sh7FFF_0000},
        '{16'sd5759,   AXIS_X,     -32'sd1, 32'sh0001_0000, 32'sh0001_0000, -32'sd1},
        '{16'sd17279,  AXIS_Y,     32'sh0010_0000, 32'sh0000_0000, 32'sh0010_0000,
          32'sh0000_0000},
        '{16'sh7FFF,   AXIS_X,     32'sh1234_5678, 32'sh0765_4321, -32'sd300000,
          32'sh1234_5678},
        '{16'sh8000,   AXIS_Y,     -32'sd123456, 32'sh5555_5555, 32'sh2AAA_AAAA,
          32'sh5555_5555},
        '{16'sd1,      AXIS_Z,     LINK_MAX, LINK_MIN, LINK_MAX, LINK_MAX},
        '{-16'sd1,     AXIS_X,     LINK_MIN, LINK_MAX, LINK_MIN, LINK_MIN},
        '{16'sd2880,   AXIS_Z,     LINK_MAX, LINK_MAX, 32'sh0000_0000, 32'sh0000_0000},
        '{16'sd2880,   AXIS_Z,     LINK_MIN, LINK_MIN, 32'sh0000_0000, 32'sh0000_0000},
        '{-16'sd2880,  AXIS_SPARE, LINK_MAX, LINK_MIN, LINK_MAX, LINK_MAX},
        '{16'sd8640,   AXIS_Y,     32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
          32'sh0000_0000},
        '{16'sd20000,  AXIS_X,     32'sh6DB6_DB6D, 32'shDEAD_BEEF, 32'sh0F0F_F0F0,
          32'sh6DB6_DB6D}
    };

    string trans_names [3] = '{"trans_x", "trans_y", "trans_z"};

    logic clk = 1'b0;
    logic rst_n;

    jht_pose_if  pose_ch ();
    jht_frame_if frame_ch ();

    frame_rec_t expected_frames [$];
    int         mismatches      = 0;
    int         frames_checked  = 0;
    int         poses_sent      = 0;
    int         rail_hits       = 0;
    int         axis_seen [4]   = '{0, 0, 0, 0};

    joint_homogeneous_transform_core #(
        .CORDIC_STEPS (STEPS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pose  (pose_ch),
        .frame (frame_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hold reset from time zero, then release for good
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Work out the transform of one pose: degree-domain CORDIC, matrix, rotated link
    function automatic frame_rec_t compute_frame(input pose_rec_t p);
        longint     lv [3];
        longint     m [3][3];
        longint     x, y, z, dx, dy, c, s, acc, t, e;
        int         r;
        int         i, j;
        bit         flip;
        frame_rec_t f;
        lv[0] = longint'($signed(p.lx));
        lv[1] = longint'($signed(p.ly));
        lv[2] = longint'($signed(p.lz));

        // Fold into (-90, 90] degrees, remembering a half-turn shift
        r    = (int'($signed(p.angle)) + 2 * ANG_FULL) % ANG_FULL;
        flip = 1'b0;
        if (r > ANG_THREE_QUARTER)
            r -= ANG_FULL;
        else if (r > ANG_QUARTER)
        begin
            r -= ANG_HALF;
            flip = 1'b1;
        end
        z = longint'(r) * 65536;
        x = GAIN_Q30;
        y = 0;

        for (i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_Q22[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_Q22[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x < -ONE_Q30) ? -ONE_Q30 : ((x > ONE_Q30) ? ONE_Q30 : x);
        s = (y < -ONE_Q30) ? -ONE_Q30 : ((y > ONE_Q30) ? ONE_Q30 : y);

        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                m[i][j] = 0;

        case (p.axis)
            AXIS_X:
            begin
                m[0][0] = ONE_Q30;
                m[1][1] = c;  m[1][2] = -s;
                m[2][1] = s;  m[2][2] = c;
            end
            AXIS_Y:
            begin
                m[0][0] = c;  m[0][2] = -s;
                m[1][1] = ONE_Q30;
                m[2][0] = s;  m[2][2] = c;
            end
            default:
            begin
                m[0][0] = c;  m[0][1] = -s;
                m[1][0] = s;  m[1][1] = c;
                m[2][2] = ONE_Q30;
            end
        endcase

        // Round entries to Q2.14, accumulate R * L and saturate to 32 bits
        for (i = 0; i < 3; i++)
        begin
            acc = 0;
            for (j = 0; j < 3; j++)
            begin
                e = (m[i][j] + 32768) >>> 16;
                f.rot[i * 3 + j] = e[15:0];
                acc += m[i][j] * lv[j];
            end
            t = (acc + (64'sd1 <<< 29)) >>> 30;
            if (t > RAIL_MAX)
                t = RAIL_MAX;
            else if (t < RAIL_MIN)
                t = RAIL_MIN;
            f.trans[i] = t[31:0];
        end
        return f;
    endfunction

    // Overwrite the entries fixed by the rotation axis: unit row and column, link passed along
    function automatic frame_rec_t pin_unit_axis(input frame_rec_t f, input axis_code_t axis,
                                                 input link_t along);
        int k;
        int j;
        case (axis)
            AXIS_X:  k = 0;
            AXIS_Y:  k = 1;
            default: k = 2;
        endcase
        for (j = 0; j < 3; j++)
        begin
            f.rot[k * 3 + j] = (j == k) ? ROT_ONE : '0;
            f.rot[j * 3 + k] = (j == k) ? ROT_ONE : '0;
        end
        f.trans[k] = along;
        return f;
    endfunction

    function automatic link_t random_link();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return ($urandom_range(0, 1) == 1) ? LINK_MAX : LINK_MIN;
        else if (pick == 1)
            return link_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        else
            return link_t'($urandom);
    endfunction

    // Mostly angles within one turn, some near quadrant edges, some over the whole field
    function automatic pose_rec_t random_pose();
        pose_rec_t p;
        int        pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            p.angle = angle_t'($urandom);
        else if (pick < 3)
            p.angle = angle_t'((int'($urandom_range(0, 8)) - 4) * ANG_QUARTER
                               + int'($urandom_range(0, 6)) - 3);
        else
            p.angle = angle_t'(int'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL);
        case ($urandom_range(0, 6))
            0, 1:    p.axis = AXIS_X;
            2, 3:    p.axis = AXIS_Y;
            4, 5:    p.axis = AXIS_Z;
            default: p.axis = AXIS_SPARE;
        endcase
        p.lx = random_link();
        p.ly = random_link();
        p.lz = random_link();
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR t=%0t frame %0d: %s", $realtime, frames_checked, what);
        mismatches++;
    endtask

    // Offer one pose after a random gap and queue its frame once the transfer happens
    task automatic send_pose(input pose_rec_t p, input frame_rec_t want);
        int gap;
        int i;
        gap = ((poses_sent % 100) < 30) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            pose_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_ch.valid       <= 1'b1;
        pose_ch.angle_deg   <= p.angle;
        pose_ch.axis_select <= p.axis;
        pose_ch.link_x      <= p.lx;
        pose_ch.link_y      <= p.ly;
        pose_ch.link_z      <= p.lz;
        do
            @(posedge clk);
        while (!pose_ch.ready);
        expected_frames.push_back(want);
        poses_sent++;
        axis_seen[p.axis]++;
        for (i = 0; i < 3; i++)
            if (want.trans[i] == LINK_MAX || want.trans[i] == LINK_MIN)
                rail_hits++;
    endtask

    // Pose source: directed table first, then random poses, then drain and judge
    initial
    begin : pose_source
        pose_rec_t  p;
        dir_row_t   row;
        int         n;
        pose_ch.valid       <= 1'b0;
        pose_ch.angle_deg   <= '0;
        pose_ch.axis_select <= AXIS_X;
        pose_ch.link_x      <= '0;
        pose_ch.link_y      <= '0;
        pose_ch.link_z      <= '0;
        do
            @(posedge clk);
        while (!rst_n);

        for (n = 0; n < DIR_N; n++)
        begin
            row     = dir_table[n];
            p.angle = row.angle;
            p.axis  = row.axis;
            p.lx    = row.lx;
            p.ly    = row.ly;
            p.lz    = row.lz;
            send_pose(p, pin_unit_axis(compute_frame(p), row.axis, row.axis_trans));
        end

        for (n = 0; n < RANDOM_POSES; n++)
        begin
            p = random_pose();
            send_pose(p, compute_frame(p));
        end
        pose_ch.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray frame
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (STEPS + 16) @(posedge clk);

        $display("Covered %0d poses (%0d directed): axis x %0d, y %0d, z %0d, spare code %0d.",
                 poses_sent, DIR_N, axis_seen[AXIS_X], axis_seen[AXIS_Y],
                 axis_seen[AXIS_Z], axis_seen[AXIS_SPARE]);
        $display("%0d frames checked, %0d translation components on a rail, %0d mismatches.",
                 frames_checked, rail_hits, mismatches);
        if (mismatches == 0)
            $display("PASS joint_homogeneous_transform_core");
        else
            $display("FAIL joint_homogeneous_transform_core");
        $finish;
    end

    // Frame sink: random stalls, idle-free stretches and two long hold-offs to back up the core
    initial
    begin : frame_sink
        int hold;
        int taken;
        frame_ch.ready <= 1'b0;
        taken = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (taken == 300 || taken == 900)
                hold = LONG_HOLD;
            else if ((taken % 128) >= 90)
                hold = 0;
            else
                hold = $urandom_range(0, 5);
            if (hold > 0)
            begin
                frame_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            frame_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!frame_ch.valid);
            taken++;
        end
    end

    // Compare every frame transfer against the oldest outstanding expectation
    always @(posedge clk)
    begin : frame_check
        frame_rec_t seen;
        frame_rec_t want;
        int         i;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            seen.rot[0]   = frame_ch.rot_00;
            seen.rot[1]   = frame_ch.rot_01;
            seen.rot[2]   = frame_ch.rot_02;
            seen.rot[3]   = frame_ch.rot_10;
            seen.rot[4]   = frame_ch.rot_11;
            seen.rot[5]   = frame_ch.rot_12;
            seen.rot[6]   = frame_ch.rot_20;
            seen.rot[7]   = frame_ch.rot_21;
            seen.rot[8]   = frame_ch.rot_22;
            seen.trans[0] = frame_ch.trans_x;
            seen.trans[1] = frame_ch.trans_y;
            seen.trans[2] = frame_ch.trans_z;
            if (expected_frames.size() == 0)
                report_mismatch("frame transfer with no pose outstanding");
            else
            begin
                want = expected_frames.pop_front();
                for (i = 0; i < 9; i++)
                    if (seen.rot[i] !== want.rot[i])
                        report_mismatch($sformatf("rot_%0d%0d got %0d expected %0d",
                                        i / 3, i % 3, $signed(seen.rot[i]),
                                        $signed(want.rot[i])));
                for (i = 0; i < 3; i++)
                    if (seen.trans[i] !== want.trans[i])
                        report_mismatch($sformatf("%s got %0d expected %0d", trans_names[i],
                                        $signed(seen.trans[i]), $signed(want.trans[i])));
            end
            frames_checked++;
        end
    end

    // Stop a hung run
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d frames outstanding.", expected_frames.size());
        $display("FAIL joint_homogeneous_transform_core");
        $finish;
    end

endmodule

[files.f]
rtl/core/jht_pkg.sv
rtl/core/jht_pose_if.sv
rtl/core/jht_frame_if.sv
rtl/core/joint_homogeneous_transform_core.sv
tb/testbench.sv
